[rtl/sle_pkg.sv]
// ----------------------------------------------------------------------------
// sle_pkg
// Shared types and codes of the sorted list engine: command and status
// codes, controller states and the controller/datapath handshake structs.
// ----------------------------------------------------------------------------
`default_nettype none

package sle_pkg;

	typedef enum logic [2:0] {
		CMD_INSERT = 3'd0,
		CMD_REMOVE = 3'd1,
		CMD_SEARCH = 3'd2,
		CMD_CLEAR  = 3'd3,
		CMD_DUMP   = 3'd4
	} cmd_e_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2,
		ST_EMPTY     = 2'd3
	} status_e_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CMP,
		S_EXEC,
		S_DUMP
	} state_e_t;

	typedef struct packed {
		logic capture;
		logic compare;
		logic exec;
		logic dump_step;
	} ctrl_t;

	typedef struct packed {
		logic out_free;
		logic go_dump;
		logic dump_last;
	} stat_t;

endpackage

`default_nettype wire

[rtl/sle_req_if.sv]
// ----------------------------------------------------------------------------
// sle_req_if
// Command channel: valid/ready handshake carrying one command beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface sle_req_if;
	logic               valid;
	logic               ready;
	logic        [2:0]  cmd;
	logic signed [31:0] value;

	modport source (output valid, output cmd, output value, input ready);
	modport sink   (input valid, input cmd, input value, output ready);
endinterface

`default_nettype wire

[rtl/sle_rsp_if.sv]
// ----------------------------------------------------------------------------
// sle_rsp_if
// Result channel: valid/ready handshake carrying one result beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface sle_rsp_if;
	logic               valid;
	logic               ready;
	logic        [1:0]  status;
	logic               found;
	logic signed [31:0] item_value;
	logic               last;
	logic        [5:0]  entry_count;

	modport source (output valid, output status, output found, output item_value,
		output last, output entry_count, input ready);
	modport sink   (input valid, input status, input found, input item_value,
		input last, input entry_count, output ready);
endinterface

`default_nettype wire

[rtl/sle_ctrl.sv]
// ----------------------------------------------------------------------------
// sle_ctrl
// Controller: sequences capture, compare, execute and the dump walk.
// ----------------------------------------------------------------------------
`default_nettype none

module sle_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_ready,
	input  wire sle_pkg::stat_t stat,
	output sle_pkg::ctrl_t      ctrl
);

	sle_pkg::state_e_t state_q;
	sle_pkg::state_e_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sle_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sle_pkg::S_IDLE: begin
				if (req_valid) state_d = sle_pkg::S_CMP;
			end
			sle_pkg::S_CMP: begin
				state_d = sle_pkg::S_EXEC;
			end
			sle_pkg::S_EXEC: begin
				if (stat.out_free) state_d = stat.go_dump ? sle_pkg::S_DUMP : sle_pkg::S_IDLE;
			end
			sle_pkg::S_DUMP: begin
				if (stat.out_free && stat.dump_last) state_d = sle_pkg::S_IDLE;
			end
			default: state_d = sle_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		ctrl      = '0;
		req_ready = 1'b0;
		unique case (state_q)
			sle_pkg::S_IDLE: begin
				req_ready    = 1'b1;
				ctrl.capture = req_valid;
			end
			sle_pkg::S_CMP: begin
				ctrl.compare = 1'b1;
			end
			sle_pkg::S_EXEC: begin
				ctrl.exec = stat.out_free;
			end
			sle_pkg::S_DUMP: begin
				ctrl.dump_step = stat.out_free;
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

[rtl/sle_datapath.sv]
// ----------------------------------------------------------------------------
// sle_datapath
// Datapath: row of sorted cells with per-cell compare, parallel shift for
// insert and remove, dump index and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sle_datapath #(
	parameter int CAPACITY = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire sle_pkg::ctrl_t     ctrl,
	output sle_pkg::stat_t          stat,
	input  wire logic        [2:0]  req_cmd,
	input  wire logic signed [31:0] req_value,
	input  wire logic               rsp_ready,
	output logic                    rsp_valid,
	output logic             [1:0]  rsp_status,
	output logic                    rsp_found,
	output logic signed      [31:0] rsp_item_value,
	output logic                    rsp_last,
	output logic             [5:0]  rsp_entry_count
);

	localparam int CNTW = $clog2(CAPACITY + 1);
	localparam int IDXW = $clog2(CAPACITY);

	logic        [2:0]      cmd_q;
	logic signed [31:0]     value_q;
	logic signed [31:0]     cell_q     [CAPACITY];
	logic signed [31:0]     cell_d     [CAPACITY];
	logic signed [31:0]     cell_below [CAPACITY];
	logic signed [31:0]     cell_above [CAPACITY];
	logic [CAPACITY-1:0]    lt_q;
	logic [CAPACITY-1:0]    eq_q;
	logic [CAPACITY-1:0]    lt_prev;
	logic [CNTW-1:0]        fill_q;
	logic [CNTW-1:0]        fill_d;
	logic [IDXW-1:0]        idx_q;
	logic                   full;
	logic                   hit;
	logic                   load_res;
	logic                   load_dump;
	sle_pkg::status_e_t     res_status;
	logic                   res_found;

	logic                   rsp_valid_q;
	sle_pkg::status_e_t     rsp_status_q;
	logic                   rsp_found_q;
	logic signed [31:0]     rsp_item_q;
	logic                   rsp_last_q;
	logic        [5:0]      rsp_count_q;

	always_ff @(posedge clk) begin
		if (ctrl.capture) begin
			cmd_q   <= req_cmd;
			value_q <= req_value;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.compare) begin
			for (int j = 0; j < CAPACITY; j++) begin
				lt_q[j] <= (CNTW'(j) < fill_q) && (cell_q[j] < value_q);
				eq_q[j] <= (CNTW'(j) < fill_q) && (cell_q[j] == value_q);
			end
		end
	end

	assign full    = (fill_q == CNTW'(CAPACITY));
	assign hit     = |eq_q;
	assign lt_prev = {lt_q[CAPACITY-2:0], 1'b1};

	always_comb begin
		cell_below[0]          = value_q;
		cell_above[CAPACITY-1] = cell_q[CAPACITY-1];
		for (int j = 1; j < CAPACITY; j++) begin
			cell_below[j]   = cell_q[j-1];
			cell_above[j-1] = cell_q[j];
		end
	end

	always_comb begin
		cell_d     = cell_q;
		fill_d     = fill_q;
		res_status = sle_pkg::ST_OK;
		res_found  = 1'b0;
		unique case (cmd_q)
			sle_pkg::CMD_INSERT: begin
				if (full) begin
					res_status = sle_pkg::ST_FULL;
				end else begin
					for (int j = 0; j < CAPACITY; j++) begin
						if (lt_q[j]) cell_d[j] = cell_q[j];
						else if (lt_prev[j]) cell_d[j] = value_q;
						else cell_d[j] = cell_below[j];
					end
					fill_d = fill_q + CNTW'(1);
				end
			end
			sle_pkg::CMD_REMOVE: begin
				if (!hit) begin
					res_status = sle_pkg::ST_NOT_FOUND;
				end else begin
					for (int j = 0; j < CAPACITY; j++) begin
						cell_d[j] = lt_q[j] ? cell_q[j] : cell_above[j];
					end
					fill_d = fill_q - CNTW'(1);
				end
			end
			sle_pkg::CMD_SEARCH: begin
				res_found  = hit;
				res_status = hit ? sle_pkg::ST_OK : sle_pkg::ST_NOT_FOUND;
			end
			sle_pkg::CMD_CLEAR: begin
				fill_d = '0;
			end
			sle_pkg::CMD_DUMP: begin
				if (fill_q == '0) res_status = sle_pkg::ST_EMPTY;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctrl.exec) cell_q <= cell_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			idx_q  <= '0;
		end else begin
			if (ctrl.exec) begin
				fill_q <= fill_d;
				idx_q  <= '0;
			end else if (ctrl.dump_step) begin
				idx_q <= idx_q + IDXW'(1);
			end
		end
	end

	assign stat.go_dump   = (cmd_q == sle_pkg::CMD_DUMP) && (fill_q != '0);
	assign stat.dump_last = ((CNTW'(idx_q) + CNTW'(1)) == fill_q);
	assign stat.out_free  = !rsp_valid_q || rsp_ready;

	assign load_res  = ctrl.exec && !stat.go_dump;
	assign load_dump = ctrl.dump_step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else begin
			if (load_res || load_dump) rsp_valid_q <= 1'b1;
			else if (rsp_ready) rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_res) begin
			rsp_status_q <= res_status;
			rsp_found_q  <= res_found;
			rsp_item_q   <= '0;
			rsp_last_q   <= 1'b1;
			rsp_count_q  <= 6'(fill_d);
		end else if (load_dump) begin
			rsp_status_q <= sle_pkg::ST_OK;
			rsp_found_q  <= 1'b0;
			rsp_item_q   <= cell_q[idx_q];
			rsp_last_q   <= stat.dump_last;
			rsp_count_q  <= 6'(fill_q);
		end
	end

	assign rsp_valid       = rsp_valid_q;
	assign rsp_status      = rsp_status_q;
	assign rsp_found       = rsp_found_q;
	assign rsp_item_value  = rsp_item_q;
	assign rsp_last        = rsp_last_q;
	assign rsp_entry_count = rsp_count_q;

endmodule

`default_nettype wire

[rtl/sorted_list_engine_core.sv]
// ----------------------------------------------------------------------------
// sorted_list_engine_core
// Bounded ascending list of signed 32-bit values with insert, remove,
// search, clear and dump commands.
//
//   channel  role    beat contents
//   req      sink    cmd, value
//   rsp      source  status, found, item_value, last, entry_count
//
// A command goes from accept to result register through capture, per-cell
// compare and execute. Dump then emits one beat per cycle per entry while
// rsp is ready; the per-cell compare and single result registers set this.
// The next command is accepted while the previous result beat still waits.
// Reset empties the list at once; rsp stalls hold execute and the dump walk.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_list_engine_core #(
	parameter int CAPACITY = 32
) (
	input  wire logic clk,
	input  wire logic arst_n,
	sle_req_if.sink   req,
	sle_rsp_if.source rsp
);

	sle_pkg::ctrl_t ctrl;
	sle_pkg::stat_t stat;

	sle_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.stat      (stat),
		.ctrl      (ctrl)
	);

	sle_datapath #(
		.CAPACITY (CAPACITY)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctrl            (ctrl),
		.stat            (stat),
		.req_cmd         (req.cmd),
		.req_value       (req.value),
		.rsp_ready       (rsp.ready),
		.rsp_valid       (rsp.valid),
		.rsp_status      (rsp.status),
		.rsp_found       (rsp.found),
		.rsp_item_value  (rsp.item_value),
		.rsp_last        (rsp.last),
		.rsp_entry_count (rsp.entry_count)
	);

	a_req_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("command accepted while previous one in flight");

	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && (rsp.status == sle_pkg::ST_EMPTY) |-> rsp.last)
		else $error("empty dump beat without last");

	a_found_is_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.found |-> (rsp.status == sle_pkg::ST_OK))
		else $error("found set with non-ok status");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && (rsp.status == sle_pkg::ST_FULL) |-> (rsp.entry_count == 6'(CAPACITY)))
		else $error("full status with count below capacity");

endmodule

`default_nettype wire
